### design/lcdws_pkg.sv
// Package for the character LCD write sequencer.
// Request, phase and job types, command and register codes, row offsets.
// No dependencies.
`default_nettype none

package lcdws_pkg;

    // Request codes
    typedef enum logic [2:0] {
        CMD_WRITE_CMD  = 3'd0,
        CMD_WRITE_DATA = 3'd1,
        CMD_GOTO       = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_INIT       = 3'd4
    } lcd_cmd_t;

    // Configuration register indexes
    localparam logic [1:0] REG_EIGHT_BIT_BUS   = 2'd0;
    localparam logic [1:0] REG_NIBBLE_ON_UPPER = 2'd1;
    localparam logic [1:0] REG_PHASE_HOLD_US   = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] HOLD_RESET = 16'd1000;

    // LCD instruction bytes
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam logic [7:0] LCD_FOUR_BIT    = 8'h02;
    localparam logic [7:0] LCD_TWO_LINE_4  = 8'h28;
    localparam logic [7:0] LCD_TWO_LINE_8  = 8'h38;
    localparam logic [7:0] LCD_CURSOR_ON   = 8'h0E;
    localparam logic [7:0] LCD_CURSOR_SET  = 8'h80;

    // Bus phases of one byte transfer; 8-bit mode stops after PH_E_LO
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_SETUP   = 3'd0;
    localparam logic [PH_W-1:0] PH_E_HI    = 3'd1;
    localparam logic [PH_W-1:0] PH_HI_DATA = 3'd2;
    localparam logic [PH_W-1:0] PH_E_LO    = 3'd3;
    localparam logic [PH_W-1:0] PH_E_HI2   = 3'd4;
    localparam logic [PH_W-1:0] PH_LO_DATA = 3'd5;
    localparam logic [PH_W-1:0] PH_E_LO2   = 3'd6;

    // Job queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [3:0] column;
    } req_t;

    typedef struct packed {
        logic        reg_select;
        logic        read_write;
        logic        enable_pin;
        logic [7:0]  data_pins;
        logic [15:0] hold_us;
        logic        last;
    } phase_t;

    // One classified request: up to four instruction/data bytes
    typedef struct packed {
        logic            rs;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } job_t;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] ofs;
        case (row)
            2'd0:    ofs = 8'h00;
            2'd1:    ofs = 8'h40;
            2'd2:    ofs = 8'h10;
            default: ofs = 8'h50;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

### design/char_lcd_write_sequencer_core.sv
// Top level of the character LCD write sequencer: configuration registers,
// front end, job queue and bus sequencer. Depends on lcdws_pkg and submodules.
`default_nettype none

// Each accepted request (command byte, data byte, goto, clear or init) becomes
// a list of LCD bus phases delivered one at a time on the phase channel,
// with last set on the final one. The bus sequencer emits one phase per cycle
// while the phase sink is ready: a byte costs 7 phases in 4-bit mode and 4 in
// 8-bit mode, so a request has 4 to 28 phases (init in 4-bit mode is the
// longest). Requests are classified up front and held in a two-entry job
// queue, so new requests are taken while the sequencer is still busy. Write
// configuration only while the block is idle.

module char_lcd_write_sequencer_core
    import lcdws_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req,
    output logic                       phase_valid,
    input  wire logic                  phase_ready,
    output phase_t                     phase,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic        eight_bit_bus_reg;
    logic        nibble_on_upper_reg;
    logic [15:0] phase_hold_us_reg;

    logic push;
    job_t push_job;
    logic q_ready;
    logic q_valid;
    job_t head;
    logic pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eight_bit_bus_reg   <= 1'b0;
            nibble_on_upper_reg <= 1'b1;
            phase_hold_us_reg   <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_EIGHT_BIT_BUS:   eight_bit_bus_reg   <= cfg_wdata[0];
                REG_NIBBLE_ON_UPPER: nibble_on_upper_reg <= cfg_wdata[0];
                REG_PHASE_HOLD_US:   phase_hold_us_reg   <= cfg_wdata[15:0];
                default:             phase_hold_us_reg   <= phase_hold_us_reg;
            endcase
        end
    end

    lcdws_front u_front (
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .eight_bit_bus (eight_bit_bus_reg),
        .push          (push),
        .push_job      (push_job),
        .q_ready       (q_ready)
    );

    lcdws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop)
    );

    lcdws_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .head            (head),
        .pop             (pop),
        .eight_bit_bus   (eight_bit_bus_reg),
        .nibble_on_upper (nibble_on_upper_reg),
        .phase_hold_us   (phase_hold_us_reg),
        .phase_valid     (phase_valid),
        .phase_ready     (phase_ready),
        .phase           (phase)
    );

endmodule

`default_nettype wire

### design/lcdws_front.sv
// Front end: accepts requests and turns each into a job of bus bytes.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_front
    import lcdws_pkg::*;
(
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    input  wire logic eight_bit_bus,
    output logic      push,
    output job_t      push_job,
    input  wire logic q_ready
);

    logic known;

    assign req_ready = q_ready;

    always_comb
    begin
        push_job          = '0;
        push_job.rs       = 1'b0;
        push_job.last_idx = 2'd0;
        known             = 1'b1;
        case (req.cmd)
            CMD_WRITE_CMD:
            begin
                push_job.bytes[0] = req.byte_value;
            end
            CMD_WRITE_DATA:
            begin
                push_job.rs       = 1'b1;
                push_job.bytes[0] = req.byte_value;
            end
            CMD_GOTO:
            begin
                push_job.bytes[0] = (row_offset(req.row) + {4'd0, req.column})
                                    | LCD_CURSOR_SET;
            end
            CMD_CLEAR:
            begin
                push_job.bytes[0] = LCD_CLEAR;
            end
            CMD_INIT:
            begin
                if (eight_bit_bus)
                begin
                    push_job.last_idx = 2'd2;
                    push_job.bytes[0] = LCD_TWO_LINE_8;
                    push_job.bytes[1] = LCD_CURSOR_ON;
                    push_job.bytes[2] = LCD_CLEAR;
                end
                else
                begin
                    push_job.last_idx = 2'd3;
                    push_job.bytes[0] = LCD_FOUR_BIT;
                    push_job.bytes[1] = LCD_TWO_LINE_4;
                    push_job.bytes[2] = LCD_CURSOR_ON;
                    push_job.bytes[3] = LCD_CLEAR;
                end
            end
            default:
            begin
                // drop unknown codes
                known = 1'b0;
            end
        endcase
    end

    assign push = req_valid && q_ready && known;

endmodule

`default_nettype wire

### design/lcdws_queue.sv
// Short job queue between the front end and the bus sequencer.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_queue
    import lcdws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      q_ready,
    output logic      q_valid,
    output job_t      head,
    input  wire logic pop
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    localparam logic [QPTR_W-1:0] PTR_MAX = QPTR_W'(QDEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

    assign q_ready = (count_reg != CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

### design/lcdws_back.sv
// Bus sequencer: walks each job byte by byte, one bus phase per cycle unless
// the phase output stalls, into a registered phase output. Depends on lcdws_pkg.
`default_nettype none

module lcdws_back
    import lcdws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire job_t        head,
    output logic             pop,
    input  wire logic        eight_bit_bus,
    input  wire logic        nibble_on_upper,
    input  wire logic [15:0] phase_hold_us,
    output logic             phase_valid,
    input  wire logic        phase_ready,
    output phase_t           phase
);

    logic [PH_W-1:0] ph_reg, ph_next;
    logic [1:0]      byte_idx_reg, byte_idx_next;
    logic [7:0]      port_reg, port_next;
    logic            sel_reg, sel_next;
    logic            strb_reg, strb_next;
    logic            out_valid_reg;
    phase_t          out_reg;

    logic [7:0] cur_byte;
    logic [3:0] nib;
    logic [7:0] nib_port;
    logic       byte_done;
    logic       job_done;
    logic       step;

    assign cur_byte  = head.bytes[byte_idx_reg];
    assign nib       = (ph_reg == PH_HI_DATA) ? cur_byte[7:4] : cur_byte[3:0];
    assign nib_port  = nibble_on_upper ? {nib, port_reg[3:0]} : {port_reg[7:4], nib};
    assign byte_done = eight_bit_bus ? (ph_reg == PH_E_LO) : (ph_reg == PH_E_LO2);
    assign job_done  = byte_done && (byte_idx_reg == head.last_idx);
    assign step      = q_valid && (!out_valid_reg || phase_ready);
    assign pop       = step && job_done;

    always_comb
    begin
        sel_next  = sel_reg;
        strb_next = strb_reg;
        port_next = port_reg;
        case (ph_reg)
            PH_SETUP:   sel_next  = head.rs;
            PH_E_HI:    strb_next = 1'b1;
            PH_HI_DATA: port_next = eight_bit_bus ? cur_byte : nib_port;
            PH_E_LO:    strb_next = 1'b0;
            PH_E_HI2:   strb_next = 1'b1;
            PH_LO_DATA: port_next = nib_port;
            PH_E_LO2:   strb_next = 1'b0;
            default:    strb_next = strb_reg;
        endcase
        ph_next       = byte_done ? PH_SETUP : ph_reg + 1'b1;
        byte_idx_next = job_done ? 2'd0 : (byte_done ? byte_idx_reg + 1'b1 : byte_idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_SETUP;
            byte_idx_reg  <= 2'd0;
            port_reg      <= 8'd0;
            sel_reg       <= 1'b0;
            strb_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                ph_reg        <= ph_next;
                byte_idx_reg  <= byte_idx_next;
                port_reg      <= port_next;
                sel_reg       <= sel_next;
                strb_reg      <= strb_next;
                out_valid_reg <= 1'b1;
            end
            else if (phase_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg.reg_select <= sel_next;
            out_reg.read_write <= 1'b0;
            out_reg.enable_pin <= strb_next;
            out_reg.data_pins  <= port_next;
            out_reg.hold_us    <= phase_hold_us;
            out_reg.last       <= job_done;
        end
    end

    assign phase_valid = out_valid_reg;
    assign phase       = out_reg;

    a_strobe_low_after_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !strb_reg)
        else $error("E left high at end of request");

    a_port_only_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ph_reg != PH_HI_DATA && ph_reg != PH_LO_DATA) |=> $stable(port_reg))
        else $error("data port changed outside a data phase");

    a_job_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (ph_reg == PH_SETUP && byte_idx_reg == 2'd0))
        else $error("sequencer not rewound after request");

endmodule

`default_nettype wire
